// ===== rtl/axi_slave_read_channel_assert.svh =====
// assertion helpers shared by the read channel modules
`ifndef AXI_SLAVE_READ_CHANNEL_ASSERT_SVH
`define AXI_SLAVE_READ_CHANNEL_ASSERT_SVH

// same-cycle implication, held off during reset
`define ASRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("asrc assertion failed");

// next-cycle implication, held off during reset
`define ASRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("asrc assertion failed");

`endif

// ===== rtl/asrc_pkg.sv =====
package asrc_pkg;

  localparam int ID_WIDTH_DEF = 4;
  localparam int ADDR_W       = 32;
  localparam int WORD_ADDR_W  = 30;
  localparam int LEN_W        = 8;
  localparam int SIZE_W       = 3;
  localparam int KIND_W       = 2;
  localparam int RESP_W       = 2;

  typedef enum logic [KIND_W-1:0] {
    BURST_FIXED = 2'd0,
    BURST_STEP  = 2'd1,
    BURST_WRAP  = 2'd2,
    BURST_RSVD  = 2'd3
  } burst_kind_t;

  typedef enum logic [1:0] {
    SIZE_BYTE  = 2'd0,
    SIZE_HALF  = 2'd1,
    SIZE_WORD  = 2'd2,
    SIZE_DWORD = 2'd3
  } size_sel_t;

  // one request, less its id
  typedef struct packed {
    logic              addr_valid;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  burst_len;
    logic [SIZE_W-1:0] beat_size;
    logic [KIND_W-1:0] burst_kind;
    logic              data_ready;
    logic              back_valid;
    logic [7:0]        back_byte;
    logic [15:0]       back_half;
    logic [31:0]       back_word;
    logic [RESP_W-1:0] back_resp;
  } asrc_req_t;

  // bus outputs of one cycle, less the id
  typedef struct packed {
    logic              addr_ready;
    logic              data_valid;
    logic [31:0]       data_word;
    logic [RESP_W-1:0] data_resp;
    logic              data_last;
  } asrc_stat_t;

  function automatic logic [31:0] replicate(input logic [1:0] sel, input logic [7:0] b,
                                            input logic [15:0] h, input logic [31:0] w);
    logic [31:0] res;
    case (sel)
      SIZE_BYTE: res = {4{b}};
      SIZE_HALF: res = {2{h}};
      default:   res = w;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/asrc_chan_if.sv =====
interface asrc_in_if #(parameter int ID_WIDTH = asrc_pkg::ID_WIDTH_DEF);
  logic                        valid;
  logic                        ready;
  logic                        addr_valid;
  logic [ID_WIDTH-1:0]         addr_id;
  logic [31:0]                 addr;
  logic [7:0]                  burst_len;
  logic [2:0]                  beat_size;
  logic [1:0]                  burst_kind;
  logic                        data_ready;
  logic                        back_valid;
  logic [7:0]                  back_byte;
  logic [15:0]                 back_half;
  logic [31:0]                 back_word;
  logic [1:0]                  back_resp;

  modport source (output valid, addr_valid, addr_id, addr, burst_len, beat_size, burst_kind,
                  data_ready, back_valid, back_byte, back_half, back_word, back_resp,
                  input ready);
  modport sink (input valid, addr_valid, addr_id, addr, burst_len, beat_size, burst_kind,
                data_ready, back_valid, back_byte, back_half, back_word, back_resp,
                output ready);
endinterface

interface asrc_out_if #(parameter int ID_WIDTH = asrc_pkg::ID_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic                addr_ready;
  logic                data_valid;
  logic [ID_WIDTH-1:0] data_id;
  logic [31:0]         data_word;
  logic [1:0]          data_resp;
  logic                data_last;

  modport source (output valid, addr_ready, data_valid, data_id, data_word, data_resp,
                  data_last, input ready);
  modport sink (input valid, addr_ready, data_valid, data_id, data_word, data_resp,
                data_last, output ready);
endinterface

// ===== rtl/asrc_core.sv =====
module asrc_core #(
  parameter int ID_WIDTH = asrc_pkg::ID_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  asrc_pkg::asrc_req_t  req,
  input  logic [ID_WIDTH-1:0]  req_id,
  output asrc_pkg::asrc_stat_t stat,
  output logic [ID_WIDTH-1:0]  stat_id
);
  import asrc_pkg::*;

  `include "axi_slave_read_channel_assert.svh"

  logic                   ready_r, ready_nxt;
  logic                   active_r, active_nxt;
  logic                   valid_r, valid_nxt;
  logic [ID_WIDTH-1:0]    id_r, id_nxt;
  logic [31:0]            data_r, data_nxt;
  logic [RESP_W-1:0]      resp_r, resp_nxt;
  logic                   last_r, last_nxt;
  logic [LEN_W-1:0]       beats_r, beats_nxt;
  logic [SIZE_W-1:0]      size_r, size_nxt;
  logic [ADDR_W-1:0]      addr_r, addr_nxt;
  logic [KIND_W-1:0]      kind_r, kind_nxt;
  logic [WORD_ADDR_W-1:0] word_addr_inc;

  assign word_addr_inc = addr_r[ADDR_W-1:ADDR_W-WORD_ADDR_W] + WORD_ADDR_W'(1);

  always_comb begin
    ready_nxt  = ready_r;
    active_nxt = active_r;
    valid_nxt  = valid_r;
    id_nxt     = id_r;
    data_nxt   = data_r;
    resp_nxt   = resp_r;
    last_nxt   = last_r;
    beats_nxt  = beats_r;
    size_nxt   = size_r;
    addr_nxt   = addr_r;
    kind_nxt   = kind_r;

    // address side
    if (!ready_r) begin
      if (!active_r) ready_nxt = 1'b1;
    end else if (req.addr_valid) begin
      ready_nxt  = 1'b0;
      active_nxt = 1'b1;
      id_nxt     = req_id;
      beats_nxt  = req.burst_len;
      size_nxt   = req.beat_size;
      addr_nxt   = req.addr;
      kind_nxt   = req.burst_kind;
      last_nxt   = (req.burst_len == '0);
    end

    // data side, overrides the address side
    if (!valid_r) begin
      if (active_r && req.back_valid) begin
        valid_nxt = 1'b1;
        data_nxt  = replicate(size_r[1:0], req.back_byte, req.back_half, req.back_word);
      end
    end else if (req.data_ready) begin
      beats_nxt = beats_r - LEN_W'(1);
      if (kind_r == BURST_STEP) addr_nxt = {word_addr_inc, 2'b00};
      if (beats_r == LEN_W'(1)) last_nxt = 1'b1;
      if (last_r) begin
        active_nxt = 1'b0;
        valid_nxt  = 1'b0;
      end else begin
        valid_nxt = req.back_valid;
      end
      if (req.back_valid) resp_nxt = req.back_resp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r  <= 1'b1;
      active_r <= 1'b0;
      valid_r  <= 1'b0;
      id_r     <= '0;
      data_r   <= '0;
      resp_r   <= '0;
      last_r   <= 1'b0;
      beats_r  <= '0;
      size_r   <= '0;
      addr_r   <= '0;
      kind_r   <= '0;
    end else if (acc) begin
      ready_r  <= ready_nxt;
      active_r <= active_nxt;
      valid_r  <= valid_nxt;
      id_r     <= id_nxt;
      data_r   <= data_nxt;
      resp_r   <= resp_nxt;
      last_r   <= last_nxt;
      beats_r  <= beats_nxt;
      size_r   <= size_nxt;
      addr_r   <= addr_nxt;
      kind_r   <= kind_nxt;
    end
  end

  assign stat.addr_ready = ready_r;
  assign stat.data_valid = valid_r;
  assign stat.data_word  = data_r;
  assign stat.data_resp  = resp_r;
  assign stat.data_last  = last_r;
  assign stat_id         = id_r;

  // a beat is only ever presented inside a burst
  `ASRC_ASSERT_NOW(a_valid_in_burst, clk, rst_n, valid_r, active_r)
  // address side is never open while a burst runs
  `ASRC_ASSERT_NOW(a_ready_idle, clk, rst_n, ready_r, !active_r)
  // taking the last beat closes the burst
  `ASRC_ASSERT_NEXT(a_last_closes, clk, rst_n,
                    acc && valid_r && req.data_ready && last_r, !active_r && !valid_r)

endmodule

// ===== rtl/asrc_outreg.sv =====
module asrc_outreg #(
  parameter int ID_WIDTH = asrc_pkg::ID_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 acc,
  input  asrc_pkg::asrc_stat_t stat,
  input  logic [ID_WIDTH-1:0]  stat_id,
  output logic                 out_valid,
  input  logic                 out_ready,
  output asrc_pkg::asrc_stat_t out_stat,
  output logic [ID_WIDTH-1:0]  out_id
);
  import asrc_pkg::*;

  `include "axi_slave_read_channel_assert.svh"

  logic                vld_r, vld_nxt;
  asrc_stat_t          stat_r;
  logic [ID_WIDTH-1:0] id_r;

  // free slot, or the held result leaves this cycle
  assign in_ready = rst_n && (!vld_r || out_ready);
  assign acc      = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (acc)            vld_nxt = 1'b1;
    else if (out_ready) vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      stat_r <= stat;
      id_r   <= stat_id;
    end
  end

  assign out_valid = vld_r;
  assign out_stat  = stat_r;
  assign out_id    = id_r;

  `ASRC_ASSERT_NEXT(a_acc_fills, clk, rst_n, acc, vld_r)
  `ASRC_ASSERT_NOW(a_empty_takes, clk, rst_n, !vld_r, in_ready)

endmodule

// ===== rtl/axi_slave_read_channel.sv =====
// Read-side slave of an AXI4-style bus, modelled one bus clock per request.
// in_ch carries one request per bus cycle: the master's address channel
// signals (addr_valid, addr_id, addr, burst_len, beat_size, burst_kind), the
// master's data_ready and the backend's data lanes and response.
// out_ch returns one result per request: addr_ready, data_valid, data_id,
// data_word, data_resp and data_last as driven during that bus cycle, that is,
// from the state before the request updates it.
// A result is registered and appears in the cycle after its request is taken.
// Throughput: one request per cycle while out_ch does not stall; the bus state
// registers and the output register are the only stages, with a single pass of logic between them.
// Byte and halfword beats are replicated across the 32-bit word; an
// incrementing burst steps the address by one word per beat.
// Reset (rst_n low, synchronous) sets addr_ready and clears the rest of the bus
// state and out_ch.valid; in_ch.ready is held low while reset is asserted.
// When out_ch stalls with a result held, in_ch.ready is low in that same
// cycle and no request is taken until the held result leaves.
module axi_slave_read_channel #(
  parameter int ID_WIDTH = asrc_pkg::ID_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  asrc_in_if.sink  in_ch,
  asrc_out_if.source out_ch
);
  import asrc_pkg::*;

  asrc_req_t           req;
  asrc_stat_t          stat;
  asrc_stat_t          out_stat;
  logic [ID_WIDTH-1:0] stat_id;
  logic [ID_WIDTH-1:0] out_id;
  logic                acc;

  assign req.addr_valid = in_ch.addr_valid;
  assign req.addr       = in_ch.addr;
  assign req.burst_len  = in_ch.burst_len;
  assign req.beat_size  = in_ch.beat_size;
  assign req.burst_kind = in_ch.burst_kind;
  assign req.data_ready = in_ch.data_ready;
  assign req.back_valid = in_ch.back_valid;
  assign req.back_byte  = in_ch.back_byte;
  assign req.back_half  = in_ch.back_half;
  assign req.back_word  = in_ch.back_word;
  assign req.back_resp  = in_ch.back_resp;

  asrc_core #(.ID_WIDTH(ID_WIDTH)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .req     (req),
    .req_id  (in_ch.addr_id),
    .stat    (stat),
    .stat_id (stat_id)
  );

  asrc_outreg #(.ID_WIDTH(ID_WIDTH)) u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .acc       (acc),
    .stat      (stat),
    .stat_id   (stat_id),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_stat  (out_stat),
    .out_id    (out_id)
  );

  assign out_ch.addr_ready = out_stat.addr_ready;
  assign out_ch.data_valid = out_stat.data_valid;
  assign out_ch.data_id    = out_id;
  assign out_ch.data_word  = out_stat.data_word;
  assign out_ch.data_resp  = out_stat.data_resp;
  assign out_ch.data_last  = out_stat.data_last;

endmodule
